### hw/rtl/rieu_pkg.sv
`default_nettype none

package rieu_pkg;

	// Architectural sizes.
	localparam int REG_COUNT   = 16;
	localparam int REG_AW      = $clog2(REG_COUNT);
	localparam int REG_FIELD_W = 4;
	localparam int MEM_WORDS   = 4096;
	localparam int MEM_AW      = $clog2(MEM_WORDS);

	// Program counter and pointer constants.
	localparam logic [31:0] RESET_PC    = 32'd4000;
	localparam logic [31:0] INSTR_BYTES = 32'd4;
	localparam logic [31:0] PTR_STEP    = 32'd4;

	// Output queue depth, a power of two.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	// Operation codes of the action field.
	typedef enum logic [4:0] {
		ACT_ADD   = 5'd0,
		ACT_SUB   = 5'd1,
		ACT_MUL   = 5'd2,
		ACT_AND   = 5'd3,
		ACT_OR    = 5'd4,
		ACT_XOR   = 5'd5,
		ACT_MOVC  = 5'd6,
		ACT_ADDL  = 5'd7,
		ACT_SUBL  = 5'd8,
		ACT_LOAD  = 5'd9,
		ACT_STORE = 5'd10,
		ACT_LDI   = 5'd11,
		ACT_STI   = 5'd12,
		ACT_CMP   = 5'd13,
		ACT_BZ    = 5'd14,
		ACT_BNZ   = 5'd15,
		ACT_BP    = 5'd16,
		ACT_BNP   = 5'd17,
		ACT_JUMP  = 5'd18,
		ACT_NOP   = 5'd19
	} action_t;

	// One decoded instruction.
	typedef struct packed {
		logic [4:0]             action;
		logic                   halt_bit;
		logic [REG_FIELD_W-1:0] dest_reg;
		logic [REG_FIELD_W-1:0] src1_reg;
		logic [REG_FIELD_W-1:0] src2_reg;
		logic signed [31:0]     immediate;
	} in_item_t;

	// One execution result.
	typedef struct packed {
		logic [31:0]        next_pc;
		logic               dest_written;
		logic signed [31:0] dest_value;
		logic               pointer_written;
		logic signed [31:0] pointer_value;
		logic               zero_out;
		logic               positive_out;
		logic               memory_written;
		logic               address_fault;
		logic               halted;
	} out_item_t;

	// Register file write bundle: destination write and pointer write.
	typedef struct packed {
		logic              dw;
		logic [REG_AW-1:0] rd;
		logic [31:0]       dv;
		logic              pw;
		logic [REG_AW-1:0] ptr;
		logic [31:0]       pv;
	} rf_wr_t;

	// Register index fields wrap modulo the register count.
	function automatic logic [REG_AW-1:0] reg_index(input logic [REG_FIELD_W-1:0] r);
		return REG_AW'(r % REG_COUNT);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rieu_channel_if.sv
`default_nettype none

// Instruction channel.
interface rieu_in_if;
	logic                valid;
	logic                ready;
	rieu_pkg::in_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// Result channel.
interface rieu_out_if;
	logic                valid;
	logic                ready;
	rieu_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### hw/rtl/rieu_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
module rieu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/rieu_regfile.sv
`default_nettype none

// Register file with two read ports and two write ports per cycle.
// Destination writes go to bank A, pointer writes to bank B; a small table of
// flip-flops records which bank holds the newest copy of each register, and
// valid bits make never-written registers read as zero. Each bank is held
// twice so that both read ports have a RAM of their own. The RAM reads are
// registered and are bypassed from the write in progress and the one just
// committed, so the data seen is always up to date.
module rieu_regfile (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rieu_pkg::REG_AW-1:0] rd_addr1,
	input  wire logic [rieu_pkg::REG_AW-1:0] rd_addr2,
	input  wire rieu_pkg::rf_wr_t            wr,
	output logic      [31:0]                 rd_data1,
	output logic      [31:0]                 rd_data2
);

	logic [31:0]                 a1_data, a2_data, b1_data, b2_data;
	logic [rieu_pkg::REG_AW-1:0] addr1_q, addr2_q;
	logic [rieu_pkg::REG_COUNT-1:0] valid_q, lvt_q;
	rieu_pkg::rf_wr_t            wr_q;

	rieu_ram #(.WIDTH(32), .DEPTH(rieu_pkg::REG_COUNT)) u_bank_a1 (
		.clk(clk), .we(wr.dw), .waddr(wr.rd), .wdata(wr.dv),
		.raddr(rd_addr1), .rdata(a1_data)
	);
	rieu_ram #(.WIDTH(32), .DEPTH(rieu_pkg::REG_COUNT)) u_bank_a2 (
		.clk(clk), .we(wr.dw), .waddr(wr.rd), .wdata(wr.dv),
		.raddr(rd_addr2), .rdata(a2_data)
	);
	rieu_ram #(.WIDTH(32), .DEPTH(rieu_pkg::REG_COUNT)) u_bank_b1 (
		.clk(clk), .we(wr.pw), .waddr(wr.ptr), .wdata(wr.pv),
		.raddr(rd_addr1), .rdata(b1_data)
	);
	rieu_ram #(.WIDTH(32), .DEPTH(rieu_pkg::REG_COUNT)) u_bank_b2 (
		.clk(clk), .we(wr.pw), .waddr(wr.ptr), .wdata(wr.pv),
		.raddr(rd_addr2), .rdata(b2_data)
	);

	// Read addresses are registered alongside the RAM read.
	always_ff @(posedge clk) begin
		addr1_q <= rd_addr1;
		addr2_q <= rd_addr2;
	end

	// Valid bits, bank select table and the last committed write.
	// The pointer write is applied last so it wins when both hit one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			lvt_q   <= '0;
			wr_q    <= '0;
		end else begin
			wr_q <= wr;
			if (wr.dw) begin
				valid_q[wr.rd] <= 1'b1;
				lvt_q[wr.rd]   <= 1'b0;
			end
			if (wr.pw) begin
				valid_q[wr.ptr] <= 1'b1;
				lvt_q[wr.ptr]   <= 1'b1;
			end
		end
	end

	// Newest value of one register: current write, then last write, then RAM.
	function automatic logic [31:0] newest(
		input logic [rieu_pkg::REG_AW-1:0] addr,
		input rieu_pkg::rf_wr_t            cur,
		input rieu_pkg::rf_wr_t            last,
		input logic                        vld,
		input logic                        sel_b,
		input logic [31:0]                 a_val,
		input logic [31:0]                 b_val
	);
		logic [31:0] v;
		if (cur.pw && cur.ptr == addr) begin
			v = cur.pv;
		end else if (cur.dw && cur.rd == addr) begin
			v = cur.dv;
		end else if (last.pw && last.ptr == addr) begin
			v = last.pv;
		end else if (last.dw && last.rd == addr) begin
			v = last.dv;
		end else if (!vld) begin
			v = '0;
		end else begin
			v = sel_b ? b_val : a_val;
		end
		return v;
	endfunction

	// Bypassed read data for both ports.
	always_comb begin
		rd_data1 = newest(addr1_q, wr, wr_q, valid_q[addr1_q], lvt_q[addr1_q],
			a1_data, b1_data);
		rd_data2 = newest(addr2_q, wr, wr_q, valid_q[addr2_q], lvt_q[addr2_q],
			a2_data, b2_data);
	end

endmodule

`default_nettype wire

### hw/rtl/rieu_out_fifo.sv
`default_nettype none

// Result queue between the execute pipeline and the result channel.
// The pipeline never stalls; the caller admits an item only when the queue
// has room for everything still in flight.
module rieu_out_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire rieu_pkg::out_item_t         push_item,
	output logic      [rieu_pkg::OUT_AW:0]   count,
	rieu_out_if.source                       result
);

	rieu_pkg::out_item_t           entry_q [rieu_pkg::OUT_DEPTH];
	logic [rieu_pkg::OUT_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [rieu_pkg::OUT_AW:0]     count_q;
	logic                          pop;

	assign pop          = result.valid && result.ready;
	assign result.valid = (count_q != '0);
	assign result.item  = entry_q[rd_ptr_q];
	assign count        = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/risc_instruction_execute_unit.sv
`default_nettype none

// Execute unit of a small 32-bit load/store processor.
// Decoded instructions arrive on the instr channel and are executed in order;
// each one produces exactly one item on the result channel. Both channels use
// valid/ready and move an item at a clock edge where both are high.
// An item accepted at one edge is executed in the next cycle (register read,
// ALU, flags, branch, data memory address) and completed in the cycle after
// (load data, register write back), after which its result enters the result
// queue. One item is accepted per cycle while instr.ready is high; throughput is
// set by the loop through the flags and program counter, with register and
// load values bypassed into the following instruction.
// Results wait in a four-entry queue; when the receiver stalls the queue
// fills and instr.ready drops once no room is left for items in flight.
// After reset the 4096-word data memory is cleared one word per cycle, and
// instr.ready stays low until that pass ends. Reset also zeroes registers
// and flags and sets the program counter to 4000. Writing cfg_wr_data with
// cfg_wr_en loads the program counter directly; the user must write it only
// while the unit is idle, which the unit itself does not enforce.
module risc_instruction_execute_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rieu_in_if.sink          instr,
	rieu_out_if.source       result,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	// Clearing pass state.
	logic                          clearing_q;
	logic [rieu_pkg::MEM_AW-1:0]   clr_cnt_q;

	// Architectural flip-flop state.
	logic [31:0] pc_q;
	logic        zero_q, pos_q, stopped_q;

	// Pipeline registers.
	logic                   v_s1, v_s2;
	rieu_pkg::in_item_t     item_s1;
	rieu_pkg::out_item_t    out_s2;
	logic                   load_s2;
	logic [rieu_pkg::REG_AW-1:0] rd_s2, ptr_s2;

	// Execute stage signals.
	logic                   accept;
	logic [31:0]            a, b, imm, res, prod, mem_addr, st_data, next;
	logic                   dw, pw, mw, fault, alu, take, is_load, zf, pf, stop;
	logic [rieu_pkg::REG_AW-1:0] rd_idx, ptr_idx;

	// Completion stage signals.
	logic [31:0]            mem_rdata, final_dv;
	rieu_pkg::rf_wr_t       rf_wr;
	rieu_pkg::out_item_t    push_item;
	logic [rieu_pkg::OUT_AW:0]   fifo_count;
	logic [rieu_pkg::OUT_AW+1:0] occupancy;

	// Data memory port.
	logic                          dm_we;
	logic [rieu_pkg::MEM_AW-1:0]   dm_waddr;
	logic [31:0]                   dm_wdata;

	// Admission: room in the queue for every item in flight plus this one.
	assign occupancy   = (rieu_pkg::OUT_AW+2)'(fifo_count)
		+ (rieu_pkg::OUT_AW+2)'(v_s1) + (rieu_pkg::OUT_AW+2)'(v_s2);
	assign instr.ready = !clearing_q
		&& (occupancy < (rieu_pkg::OUT_AW+2)'(rieu_pkg::OUT_DEPTH));
	assign accept      = instr.valid && instr.ready;

	rieu_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr1 (rieu_pkg::reg_index(instr.item.src1_reg)),
		.rd_addr2 (rieu_pkg::reg_index(instr.item.src2_reg)),
		.wr       (rf_wr),
		.rd_data1 (a),
		.rd_data2 (b)
	);

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Instruction capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= instr.item;
		end
	end

	assign imm     = item_s1.immediate;
	assign rd_idx  = rieu_pkg::reg_index(item_s1.dest_reg);
	assign ptr_idx = rieu_pkg::reg_index(item_s1.src1_reg);
	assign prod    = a * b;

	// Store uses src2 as base; every other access uses src1.
	assign mem_addr = (item_s1.action == rieu_pkg::ACT_STORE) ? (b + imm) : (a + imm);
	assign st_data  = (item_s1.action == rieu_pkg::ACT_STORE) ? a : b;

	// Execute: ALU, flags, branches and memory access decisions.
	always_comb begin
		next    = pc_q + rieu_pkg::INSTR_BYTES;
		dw      = 1'b0;
		pw      = 1'b0;
		mw      = 1'b0;
		fault   = 1'b0;
		alu     = 1'b0;
		take    = 1'b0;
		is_load = 1'b0;
		res     = '0;
		zf      = zero_q;
		pf      = pos_q;
		stop    = stopped_q;
		if (stopped_q) begin
			next = pc_q;
		end else if (item_s1.halt_bit) begin
			stop = 1'b1;
		end else begin
			unique case (item_s1.action) inside
				rieu_pkg::ACT_ADD: begin
					res = a + b;
					alu = 1'b1;
				end
				rieu_pkg::ACT_SUB: begin
					res = a - b;
					alu = 1'b1;
				end
				rieu_pkg::ACT_MUL: begin
					res = prod;
					alu = 1'b1;
				end
				rieu_pkg::ACT_AND: begin
					res = a & b;
					alu = 1'b1;
				end
				rieu_pkg::ACT_OR: begin
					res = a | b;
					alu = 1'b1;
				end
				rieu_pkg::ACT_XOR: begin
					res = a ^ b;
					alu = 1'b1;
				end
				rieu_pkg::ACT_MOVC: begin
					res = imm;
					alu = 1'b1;
				end
				rieu_pkg::ACT_ADDL: begin
					res = a + imm;
					alu = 1'b1;
				end
				rieu_pkg::ACT_SUBL: begin
					res = a - imm;
					alu = 1'b1;
				end
				rieu_pkg::ACT_LOAD, rieu_pkg::ACT_LDI: begin
					fault   = (mem_addr >= 32'(rieu_pkg::MEM_WORDS));
					is_load = !fault;
					dw      = 1'b1;
					pw      = (item_s1.action == rieu_pkg::ACT_LDI);
				end
				rieu_pkg::ACT_STORE, rieu_pkg::ACT_STI: begin
					fault = (mem_addr >= 32'(rieu_pkg::MEM_WORDS));
					mw    = !fault;
					pw    = (item_s1.action == rieu_pkg::ACT_STI);
				end
				rieu_pkg::ACT_CMP: begin
					zf = (a == b);
					pf = ($signed(a) > $signed(b));
				end
				rieu_pkg::ACT_BZ:   take = zero_q;
				rieu_pkg::ACT_BNZ:  take = !zero_q;
				rieu_pkg::ACT_BP:   take = pos_q;
				rieu_pkg::ACT_BNP:  take = !pos_q;
				rieu_pkg::ACT_JUMP: next = a + imm;
				default: begin
				end
			endcase
			if (alu) begin
				dw = 1'b1;
				zf = (res == '0);
				pf = (res != '0) && !res[31];
			end
			if (take) begin
				next = pc_q + imm;
			end
		end
	end

	// Program counter, flags and stopped bit advance once per executed item.
	// A halt reports the following address but leaves the counter in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= rieu_pkg::RESET_PC;
			zero_q    <= 1'b0;
			pos_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (cfg_wr_en) begin
			pc_q <= cfg_wr_data;
		end else if (v_s1) begin
			if (!item_s1.halt_bit) begin
				pc_q <= next;
			end
			zero_q    <= zf;
			pos_q     <= pf;
			stopped_q <= stop;
		end
	end

	// Clearing pass over the data memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == rieu_pkg::MEM_AW'(rieu_pkg::MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Data memory: stores write in the execute stage, loads read there too.
	assign dm_we    = clearing_q || (v_s1 && mw);
	assign dm_waddr = clearing_q ? clr_cnt_q : mem_addr[rieu_pkg::MEM_AW-1:0];
	assign dm_wdata = clearing_q ? '0 : st_data;

	rieu_ram #(.WIDTH(32), .DEPTH(rieu_pkg::MEM_WORDS)) u_data_mem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.raddr (mem_addr[rieu_pkg::MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	// Completion stage register.
	always_ff @(posedge clk) begin
		out_s2.next_pc         <= next;
		out_s2.dest_written    <= dw;
		out_s2.dest_value      <= res;
		out_s2.pointer_written <= pw;
		out_s2.pointer_value   <= pw ? (a + rieu_pkg::PTR_STEP) : '0;
		out_s2.zero_out        <= zf;
		out_s2.positive_out    <= pf;
		out_s2.memory_written  <= mw;
		out_s2.address_fault   <= fault;
		out_s2.halted          <= stop;
		load_s2                <= is_load;
		rd_s2                  <= rd_idx;
		ptr_s2                 <= ptr_idx;
	end

	// Load data joins here; write back and hand the result to the queue.
	assign final_dv = load_s2 ? mem_rdata : out_s2.dest_value;

	always_comb begin
		rf_wr.dw  = v_s2 && out_s2.dest_written;
		rf_wr.rd  = rd_s2;
		rf_wr.dv  = final_dv;
		rf_wr.pw  = v_s2 && out_s2.pointer_written;
		rf_wr.ptr = ptr_s2;
		rf_wr.pv  = out_s2.pointer_value;
		push_item = out_s2;
		push_item.dest_value = final_dv;
	end

	rieu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_item (push_item),
		.count     (fifo_count),
		.result    (result)
	);

endmodule

`default_nettype wire

### sim/rieu_exec_checker.sv
`default_nettype none

// Watches both channels and the start address port, predicts each result from its
// own copy of the architectural state, and compares the results in order.
module rieu_exec_checker
	import rieu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	rieu_in_if               instr_mon,
	rieu_out_if              result_mon,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	output int               error_count,
	output int               accepted_count,
	output int               result_count,
	output int               store_count,
	output int               fault_count
);

	localparam int MAX_PRINTED = 40;

	// Architectural state as the predictor sees it.
	logic [31:0] gpr [REG_COUNT];
	logic [31:0] dmem [MEM_WORDS];
	logic [31:0] pc_q;
	logic        zf;
	logic        pf;
	logic        stopped;

	// Results predicted but not yet seen on the result channel.
	out_item_t   outcome_q [$];

	// Runs one instruction on the local state and returns its result item.
	function automatic out_item_t run_instruction(input in_item_t op);
		out_item_t         r;
		logic [31:0]       a;
		logic [31:0]       b;
		logic [31:0]       imm;
		logic [31:0]       nxt;
		logic [31:0]       res;
		logic [31:0]       addr;
		logic [REG_AW-1:0] rd;
		logic [REG_AW-1:0] r1;
		logic [REG_AW-1:0] r2;
		logic              alu;
		logic              take;
		r    = '0;
		rd   = REG_AW'(op.dest_reg % REG_COUNT);
		r1   = REG_AW'(op.src1_reg % REG_COUNT);
		r2   = REG_AW'(op.src2_reg % REG_COUNT);
		a    = gpr[r1];
		b    = gpr[r2];
		imm  = op.immediate;
		nxt  = pc_q + INSTR_BYTES;
		res  = '0;
		addr = '0;
		alu  = 1'b0;
		take = 1'b0;
		if (stopped) begin
			nxt = pc_q;
		end else if (op.halt_bit) begin
			stopped = 1'b1;
		end else begin
			case (op.action)
				ACT_ADD: begin res = a + b; alu = 1'b1; end
				ACT_SUB: begin res = a - b; alu = 1'b1; end
				ACT_MUL: begin res = a * b; alu = 1'b1; end
				ACT_AND: begin res = a & b; alu = 1'b1; end
				ACT_OR: begin res = a | b; alu = 1'b1; end
				ACT_XOR: begin res = a ^ b; alu = 1'b1; end
				ACT_MOVC: begin res = imm; alu = 1'b1; end
				ACT_ADDL: begin res = a + imm; alu = 1'b1; end
				ACT_SUBL: begin res = a - imm; alu = 1'b1; end
				ACT_LOAD, ACT_LDI: begin
					// A faulting load still writes zero to the destination.
					addr = a + imm;
					r.address_fault = addr >= 32'(MEM_WORDS);
					r.dest_value = r.address_fault ? '0 : dmem[addr[MEM_AW-1:0]];
					r.dest_written = 1'b1;
					if (op.action == ACT_LDI) begin
						r.pointer_value = a + PTR_STEP;
						r.pointer_written = 1'b1;
					end
				end
				ACT_STORE, ACT_STI: begin
					if (op.action == ACT_STORE) begin
						addr = b + imm;
						res = a;
					end else begin
						addr = a + imm;
						res = b;
						r.pointer_value = a + PTR_STEP;
						r.pointer_written = 1'b1;
					end
					r.address_fault = addr >= 32'(MEM_WORDS);
					if (!r.address_fault) begin
						dmem[addr[MEM_AW-1:0]] = res;
						r.memory_written = 1'b1;
					end
				end
				ACT_CMP: begin
					zf = a == b;
					pf = $signed(a) > $signed(b);
				end
				ACT_BZ: take = zf;
				ACT_BNZ: take = !zf;
				ACT_BP: take = pf;
				ACT_BNP: take = !pf;
				ACT_JUMP: nxt = a + imm;
				default: begin
				end
			endcase
			if (alu) begin
				r.dest_value = res;
				r.dest_written = 1'b1;
				zf = res == '0;
				pf = res != '0 && !res[31];
			end
			if (take) begin
				nxt = pc_q + imm;
			end
			// The pointer update is applied last, so it wins over a load to the same register.
			if (r.dest_written) begin
				gpr[rd] = r.dest_value;
			end
			if (r.pointer_written) begin
				gpr[r1] = r.pointer_value;
			end
			pc_q = nxt;
		end
		r.next_pc = nxt;
		r.zero_out = zf;
		r.positive_out = pf;
		r.halted = stopped;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		error_count = error_count + 1;
		if (error_count <= MAX_PRINTED) begin
			$display("Mismatch in result %0d, %s: got 0x%h, expected 0x%h",
				result_count, field, got, want);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(field, got, want);
		end
	endtask

	// Prediction on each accepted item, comparison on each delivered result.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				gpr[i] = '0;
			end
			for (int i = 0; i < MEM_WORDS; i++) begin
				dmem[i] = '0;
			end
			pc_q = RESET_PC;
			zf = 1'b0;
			pf = 1'b0;
			stopped = 1'b0;
			outcome_q.delete();
			error_count = 0;
			store_count = 0;
			fault_count = 0;
			accepted_count <= 0;
			result_count <= 0;
		end else begin
			// A start address write reloads the program counter at once.
			if (cfg_wr_en) begin
				pc_q = cfg_wr_data;
			end
			if (instr_mon.valid && instr_mon.ready) begin
				want = run_instruction(instr_mon.item);
				store_count = store_count + int'(want.memory_written);
				fault_count = fault_count + int'(want.address_fault);
				outcome_q.push_back(want);
				accepted_count <= accepted_count + 1;
			end
			if (result_mon.valid && result_mon.ready) begin
				result_count <= result_count + 1;
				if (outcome_q.size() == 0) begin
					report_mismatch("item with no instruction waiting",
						result_mon.item.next_pc, '0);
				end else begin
					want = outcome_q.pop_front();
					check_field("next_pc", result_mon.item.next_pc, want.next_pc);
					check_field("dest_written", 32'(result_mon.item.dest_written),
						32'(want.dest_written));
					check_field("dest_value", result_mon.item.dest_value, want.dest_value);
					check_field("pointer_written", 32'(result_mon.item.pointer_written),
						32'(want.pointer_written));
					check_field("pointer_value", result_mon.item.pointer_value,
						want.pointer_value);
					check_field("zero_out", 32'(result_mon.item.zero_out), 32'(want.zero_out));
					check_field("positive_out", 32'(result_mon.item.positive_out),
						32'(want.positive_out));
					check_field("memory_written", 32'(result_mon.item.memory_written),
						32'(want.memory_written));
					check_field("address_fault", 32'(result_mon.item.address_fault),
						32'(want.address_fault));
					check_field("halted", 32'(result_mon.item.halted), 32'(want.halted));
				end
			end
		end
	end

endmodule

`default_nettype wire

### sim/tb_risc_instruction_execute_unit.sv
`default_nettype none

module tb_risc_instruction_execute_unit;
	import rieu_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 310;
	localparam int SETTLE_CYCLES   = 4;

	// Registers used by the directed program.
	localparam logic [3:0] R_POS = 4'd1;
	localparam logic [3:0] R_NEG = 4'd2;
	localparam logic [3:0] R_SUM = 4'd3;
	localparam logic [3:0] R_TOP = 4'd11;
	localparam logic [3:0] R_TMP = 4'd12;

	// An action code outside the defined set, which executes as a nop.
	localparam logic [4:0] ACT_SPARE = 5'd31;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	rieu_in_if  instr_ch ();
	rieu_out_if result_ch ();

	int error_count;
	int accepted_count;
	int result_count;
	int store_count;
	int fault_count;
	int cycle_count = 0;
	int issued = 0;
	bit quick_source = 1'b0;
	bit quick_sink = 1'b0;

	risc_instruction_execute_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	rieu_exec_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.instr_mon      (instr_ch),
		.result_mon     (result_ch),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.error_count    (error_count),
		.accepted_count (accepted_count),
		.result_count   (result_count),
		.store_count    (store_count),
		.fault_count    (fault_count)
	);

	always #10 clk = ~clk;

	// Hard stop in case the unit hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still missing", cycle_count,
				accepted_count - result_count);
			$display("tb_risc_instruction_execute_unit failed");
			$finish;
		end
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_idle(input bit quick);
		int roll;
		roll = $urandom_range(0, 99);
		if (quick || roll < 60) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		if (roll < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [3:0] rand_reg();
		return 4'($urandom_range(0, 15));
	endfunction

	// Immediates: small offsets, boundary values and full-range values.
	function automatic logic [31:0] rand_imm();
		case ($urandom_range(0, 7))
			0, 1: return $urandom_range(0, 32) - 32'd16;
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_0000;
					default: return 32'h0000_0001;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// Offers one instruction item and waits until it is taken.
	task automatic push_op(input logic [4:0] act, input logic [3:0] rd, input logic [3:0] rs1,
			input logic [3:0] rs2, input logic [31:0] imm, input logic halt = 1'b0);
		in_item_t it;
		int       idle;
		it.action    = act;
		it.halt_bit  = halt;
		it.dest_reg  = rd;
		it.src1_reg  = rs1;
		it.src2_reg  = rs2;
		it.immediate = imm;
		if ($urandom_range(0, 99) == 0) begin
			quick_source = !quick_source;
		end
		idle = pick_idle(quick_source);
		if (idle != 0) begin
			instr_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.item <= it;
		do @(posedge clk); while (!instr_ch.ready);
		issued++;
	endtask

	// Waits until every accepted item has produced its result, then lets the pipe settle.
	task automatic wait_drained();
		instr_ch.valid <= 1'b0;
		do @(posedge clk); while (accepted_count > result_count);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result receiver with random stalls.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			result_ch.ready <= 1'b1;
			@(posedge clk);
			if ($urandom_range(0, 499) == 0) begin
				quick_sink = !quick_sink;
			end
			stall = $urandom_range(0, 1) ? pick_idle(quick_sink) : 0;
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int          phase;
		int          goal;
		int          kind;
		int          len;
		logic [3:0]  ptr;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  rc;
		logic [31:0] base;
		logic [31:0] next_start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.item = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed program: boundary values, every operation, faults and pointer forms.
		push_op(ACT_MOVC, R_POS, R_TMP, R_TMP, 32'h7FFF_FFFF);
		push_op(ACT_MOVC, R_NEG, R_TMP, R_TMP, 32'h8000_0000);
		push_op(ACT_ADD, R_SUM, R_POS, R_NEG, '0);
		push_op(ACT_SUB, R_TMP, R_NEG, R_POS, '0);
		push_op(ACT_MUL, R_TMP, R_POS, R_NEG, '0);
		push_op(ACT_AND, R_TMP, R_POS, R_NEG, '0);
		push_op(ACT_BZ, R_TMP, R_TMP, R_TMP, 32'hFFFF_FFF8);
		push_op(ACT_OR, R_TMP, R_POS, R_NEG, '0);
		push_op(ACT_XOR, R_TMP, R_SUM, R_SUM, '0);
		push_op(ACT_BNZ, R_TMP, R_TMP, R_TMP, 32'd64);
		push_op(ACT_ADDL, R_TMP, R_POS, R_TMP, 32'd1);
		push_op(ACT_BNP, R_TMP, R_TMP, R_TMP, 32'hFFFF_FF00);
		push_op(ACT_SUBL, R_TMP, R_NEG, R_TMP, 32'd1);
		push_op(ACT_CMP, R_TMP, R_POS, R_NEG, '0);
		push_op(ACT_BP, R_TMP, R_TMP, R_TMP, 32'h0000_0100);
		// Last word of data memory, one past it, and a negative address.
		push_op(ACT_MOVC, R_TOP, R_TMP, R_TMP, 32'(MEM_WORDS - 1));
		push_op(ACT_STORE, R_TMP, R_POS, R_TOP, '0);
		push_op(ACT_LOAD, R_TMP, R_TOP, R_TMP, '0);
		push_op(ACT_STORE, R_TMP, R_POS, R_TOP, 32'd1);
		push_op(ACT_LOAD, R_TMP, R_TOP, R_TMP, 32'd1);
		push_op(ACT_LOAD, R_TMP, R_NEG, R_TMP, '0);
		// Pointer forms back to word zero; the load targets its own pointer register.
		push_op(ACT_STI, R_TMP, R_TOP, R_SUM, 32'(1 - MEM_WORDS));
		push_op(ACT_LDI, R_TOP, R_TOP, R_TMP, 32'(-MEM_WORDS - 3));
		push_op(ACT_JUMP, R_TMP, R_POS, R_TMP, 32'd1);
		push_op(ACT_NOP, R_TMP, R_TMP, R_TMP, '0);
		push_op(ACT_SPARE, R_TMP, R_TMP, R_TMP, 32'hFFFF_FFFF);

		// Random phases, each under its own start address.
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				wait_drained();
				case (phase)
					1: next_start = 32'h0000_0000;
					2: next_start = 32'hFFFF_FFFC;
					3: next_start = 32'hFFFF_FFFF;
					4: next_start = $urandom();
					default: next_start = 32'h8000_0000;
				endcase
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= next_start;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
			end
			goal = issued + ITEMS_PER_PHASE;
			while (issued < goal) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					// Memory burst through one pointer, often in regions already written.
					ptr = rand_reg();
					case ($urandom_range(0, 3))
						0: base = $urandom_range(0, 15);
						1: base = $urandom_range(MEM_WORDS - 40, MEM_WORDS - 1);
						default: base = 256 * $urandom_range(0, 3) + $urandom_range(0, 63);
					endcase
					push_op(ACT_MOVC, ptr, rand_reg(), rand_reg(), base);
					len = $urandom_range(3, 8);
					repeat (len) begin
						case ($urandom_range(0, 3))
							0: push_op(ACT_STI, rand_reg(), ptr, rand_reg(), $urandom_range(0, 8));
							1: push_op(ACT_LDI, rand_reg(), ptr, rand_reg(), $urandom_range(0, 8));
							2: push_op(ACT_LOAD, rand_reg(), ptr, rand_reg(),
								$urandom_range(0, 32) - 32'd16);
							default: push_op(ACT_STORE, rand_reg(), rand_reg(), ptr,
								$urandom_range(0, 32) - 32'd16);
						endcase
					end
				end else if (kind < 7) begin
					// Arithmetic chain, sometimes a compare, then a branch or jump on the result.
					ra = rand_reg();
					rb = rand_reg();
					push_op(ACT_MOVC, ra, rand_reg(), rand_reg(), rand_imm());
					push_op(ACT_MOVC, rb, rand_reg(), rand_reg(), rand_imm());
					len = $urandom_range(1, 4);
					repeat (len) begin
						rc = rand_reg();
						push_op(5'($urandom_range(ACT_ADD, ACT_SUBL)), rc, ra,
							$urandom_range(0, 1) ? rb : rc, rand_imm());
						ra = rc;
					end
					if ($urandom_range(0, 1)) begin
						push_op(ACT_CMP, rand_reg(), ra, $urandom_range(0, 4) == 0 ? ra : rb,
							rand_imm());
					end
					push_op(5'($urandom_range(ACT_BZ, ACT_JUMP)), rand_reg(), ra, rb, rand_imm());
				end else begin
					// Any action code, any fields.
					push_op(5'($urandom_range(0, 31)), rand_reg(), rand_reg(), rand_reg(),
						rand_imm());
				end
			end
		end

		// Halt, then items that must have no effect.
		push_op(5'($urandom_range(0, 31)), rand_reg(), rand_reg(), rand_reg(), rand_imm(), 1'b1);
		repeat (8) begin
			push_op(5'($urandom_range(0, 31)), rand_reg(), rand_reg(), rand_reg(), rand_imm(),
				1'($urandom_range(0, 1)));
		end
		wait_drained();

		$display("Ran %0d instructions over %0d start addresses, ending with a halt.",
			issued, PHASES);
		$display("Checked %0d results, including %0d stores and %0d address faults.",
			result_count, store_count, fault_count);
		if (error_count == 0) begin
			$display("tb_risc_instruction_execute_unit passed");
		end else begin
			$display("tb_risc_instruction_execute_unit failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
